/* hw/rtl/range_digit_sum_total_assert.svh */
// ----------------------------------------------------------------------------
// range_digit_sum_total assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RANGE_DIGIT_SUM_TOTAL_ASSERT_SVH
`define RANGE_DIGIT_SUM_TOTAL_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RDST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range_digit_sum_total: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define RDST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range_digit_sum_total: next-cycle check failed");

`endif

/* hw/rtl/rdst_pkg.sv */
// ----------------------------------------------------------------------------
// rdst_pkg
// Shared constants, types and helper functions for range_digit_sum_total.
// ----------------------------------------------------------------------------
package rdst_pkg;

    localparam int MAX_DIGITS_DEF = 17;
    localparam int BIN_W          = 57;
    localparam int TOTAL_W        = 63;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_WALK,
        ST_RESULT
    } state_t;

    // elaboration-time power of ten
    function automatic logic [63:0] pow10(input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < e; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // d*(d-1)/2, sum of all digit values below d
    function automatic logic [5:0] tri_sum(input logic [3:0] d);
        logic [7:0] p;
        p = {4'b0, d} * ({4'b0, d} - 8'd1);
        return p[6:1];
    endfunction

endpackage

/* hw/rtl/range_digit_sum_total.sv */
// An empty range (range_low > range_high) skips conversion and the walk and goes straight to
// the result state. One query at a time: a result waits in the result state while the output
// drains; the next word is taken once the previous result sits in the output register. Time is
// set by the BCD shift register (two bits a cycle) and the digit walk (one digit a cycle).
// Reset (rst_n, async, active low) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// range_digit_sum_total
// Sum of decimal digit sums over [range_low, range_high] as F(high)-F(low-1).
// ----------------------------------------------------------------------------
module range_digit_sum_total #(
    parameter int MAX_DIGITS = rdst_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rdst_pkg::BIN_W-1:0]    range_low,
    input  logic [rdst_pkg::BIN_W-1:0]    range_high,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rdst_pkg::TOTAL_W-1:0]  digit_sum_total,
    output logic                          range_error
);

    localparam int BIN_W = rdst_pkg::BIN_W;
    localparam int T_W   = rdst_pkg::TOTAL_W;
    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam logic [BIN_W-1:0] CAP = BIN_W'(rdst_pkg::pow10(MAX_DIGITS) - 64'd1);

    rdst_pkg::state_t state_reg, state_next;

    logic             accept;
    logic             err;
    logic [BIN_W-1:0] hi_arg;
    logic [BIN_W-1:0] lo_arg;
    logic             conv_start;
    logic             load_out;

    logic             conv_done_hi, conv_done_lo;
    logic [BCD_W-1:0] bcd_hi, bcd_lo;
    logic             walk_done_hi, walk_done_lo;
    logic [T_W-1:0]   f_hi, f_lo;

    logic             err_pend_reg;
    logic [T_W-1:0]   total_reg;
    logic             err_reg;
    logic             out_valid_reg;

    assign accept = in_valid && in_ready;
    assign err    = range_low > range_high;

    always_comb
    begin
        hi_arg = (range_high > CAP) ? CAP : range_high;
        if (range_low == '0)
        begin
            lo_arg = '0;
        end
        else if (range_low > CAP)
        begin
            lo_arg = CAP - BIN_W'(1);
        end
        else
        begin
            lo_arg = range_low - BIN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        conv_start = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            rdst_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    conv_start = !err;
                    state_next = err ? rdst_pkg::ST_RESULT : rdst_pkg::ST_CONV;
                end
            end
            rdst_pkg::ST_CONV:
            begin
                if (conv_done_hi)
                begin
                    state_next = rdst_pkg::ST_WALK;
                end
            end
            rdst_pkg::ST_WALK:
            begin
                if (walk_done_hi)
                begin
                    state_next = rdst_pkg::ST_RESULT;
                end
            end
            rdst_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = rdst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdst_pkg::ST_IDLE;
            end
        endcase
    end

    rdst_bcd_conv #(.MAX_DIGITS(MAX_DIGITS)) u_conv_hi (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .bin_in (hi_arg),
        .done   (conv_done_hi),
        .bcd    (bcd_hi)
    );

    rdst_bcd_conv #(.MAX_DIGITS(MAX_DIGITS)) u_conv_lo (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .bin_in (lo_arg),
        .done   (conv_done_lo),
        .bcd    (bcd_lo)
    );

    rdst_digit_walk #(.MAX_DIGITS(MAX_DIGITS)) u_walk_hi (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_done_hi),
        .bcd_in (bcd_hi),
        .done   (walk_done_hi),
        .total  (f_hi)
    );

    // lower bound of zero converts 0, whose prefix total is 0
    rdst_digit_walk #(.MAX_DIGITS(MAX_DIGITS)) u_walk_lo (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_done_lo),
        .bcd_in (bcd_lo),
        .done   (walk_done_lo),
        .total  (f_lo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            err_pend_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                err_pend_reg <= err;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            total_reg <= err_pend_reg ? '0 : (f_hi - f_lo);
            err_reg   <= err_pend_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign digit_sum_total = total_reg;
    assign range_error     = err_reg;

`include "range_digit_sum_total_assert.svh"

    `RDST_ASSERT_SAME(a_err_zero, out_valid && range_error, digit_sum_total == '0)
    `RDST_ASSERT_SAME(a_walk_lockstep, 1'b1, walk_done_hi == walk_done_lo)
    `RDST_ASSERT_NEXT(a_conv_to_walk, conv_done_hi, state_reg == rdst_pkg::ST_WALK)
    `RDST_ASSERT_NEXT(a_accept_busy, accept, state_reg != rdst_pkg::ST_IDLE)

endmodule

/* hw/rtl/rdst_bcd_conv.sv */
// ----------------------------------------------------------------------------
// rdst_bcd_conv
// Shift-add-3 binary to BCD converter, two binary bits per cycle.
// ----------------------------------------------------------------------------
module rdst_bcd_conv #(
    parameter int MAX_DIGITS = rdst_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rdst_pkg::BIN_W-1:0]    bin_in,
    output logic                          done,
    output logic [4*MAX_DIGITS-1:0]       bcd
);

    localparam int STEPS = (rdst_pkg::BIN_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int BCD_W = 4 * MAX_DIGITS;

    logic [PAD_W-1:0] bin_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_comb
    begin
        logic [BCD_W-1:0] b;
        b = bcd_reg;
        for (int k = 0; k < 2; k++)
        begin
            for (int g = 0; g < MAX_DIGITS; g++)
            begin
                if (b[g*4 +: 4] >= 4'd5)
                begin
                    b[g*4 +: 4] = b[g*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], bin_reg[PAD_W-1-k]};
        end
        bcd_next = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= PAD_W'(bin_in);
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= bin_reg << 2;
            bcd_reg <= bcd_next;
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

/* hw/rtl/rdst_digit_walk.sv */
// ----------------------------------------------------------------------------
// rdst_digit_walk
// Tight-bound digit walk, one decimal digit per cycle, MSD first.
// Accumulates the prefix digit-sum total by Horner steps in base ten.
// ----------------------------------------------------------------------------
module rdst_digit_walk #(
    parameter int MAX_DIGITS = rdst_pkg::MAX_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [4*MAX_DIGITS-1:0]       bcd_in,
    output logic                          done,
    output logic [rdst_pkg::TOTAL_W-1:0]  total
);

    localparam int BCD_W  = 4 * MAX_DIGITS;
    localparam int IDX_W  = $clog2(MAX_DIGITS + 1);
    localparam int HSUM_W = $clog2(9 * MAX_DIGITS + 1);
    localparam int C_W    = $clog2(81 * MAX_DIGITS + 37);
    localparam int FREE_W = $clog2(405 * MAX_DIGITS + 1);
    localparam int T_W    = rdst_pkg::TOTAL_W;

    logic [BCD_W-1:0]  dig_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [HSUM_W-1:0] hsum_reg;
    logic [FREE_W-1:0] free_reg;
    logic [T_W-1:0]    acc_reg;
    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;

    logic [3:0]        d;
    logic [C_W-1:0]    c;
    logic [FREE_W-1:0] free_next;
    logic [T_W-1:0]    acc_next;

    assign d = dig_reg[BCD_W-1 -: 4];

    // digit values below d open free suffixes: (H+j)*10^i summed over j<d,
    // plus the suffix digit sums, added one place lower on the next step
    always_comb
    begin
        c         = C_W'(d) * C_W'(hsum_reg) + C_W'(rdst_pkg::tri_sum(d));
        free_next = FREE_W'(d) * FREE_W'(idx_reg) * FREE_W'(45);
        acc_next  = (acc_reg << 3) + (acc_reg << 1) + T_W'(c) + T_W'(free_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= IDX_W'(MAX_DIGITS - 1);
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg - IDX_W'(1);
                if (idx_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dig_reg  <= bcd_in;
            hsum_reg <= '0;
            free_reg <= '0;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dig_reg  <= dig_reg << 4;
            hsum_reg <= hsum_reg + HSUM_W'(d);
            free_reg <= free_next;
            acc_reg  <= acc_next;
        end
        else if (fin_reg)
        begin
            // N itself contributes the digit sum of the tight path
            acc_reg <= acc_reg + T_W'(hsum_reg);
        end
    end

    assign done  = done_reg;
    assign total = acc_reg;

endmodule
